>>> rtl/crcvw_pkg.sv
// ----------------------------------------------------------------------------
// CRC variable width package
// Shared constants, configuration register indexes and the configuration
// struct for the configurable-width byte-stream CRC.
// ----------------------------------------------------------------------------
package crcvw_pkg;

    localparam int MAX_WIDTH_DEFAULT = 16;
    localparam int MIN_WIDTH         = 8;
    localparam int BYTE_W            = 8;
    localparam int CFG_WIDTH_W       = 5;
    localparam int POLY_W            = 16;
    localparam int CRC_W             = 16;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 16;

    localparam logic [CFG_WIDTH_W-1:0] CRC_WIDTH_RESET  = CFG_WIDTH_W'(16);
    localparam logic [POLY_W-1:0]      POLYNOMIAL_RESET = 16'h1021;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_WIDTH  = 1'b0,
        CFG_POLYNOMIAL = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_WIDTH_W-1:0] width;
        logic [POLY_W-1:0]      poly;
    } crc_cfg_t;

endpackage

>>> rtl/crcvw_cfg.sv
// ----------------------------------------------------------------------------
// CRC configuration registers
// Holds the width and polynomial registers and presents the width
// saturated to the supported range.
// ----------------------------------------------------------------------------
module crcvw_cfg
    import crcvw_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output crc_cfg_t              cfg
);

    logic [CFG_WIDTH_W-1:0] width_reg;
    logic [POLY_W-1:0]      poly_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= CRC_WIDTH_RESET;
            poly_reg  <= POLYNOMIAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_CRC_WIDTH:  width_reg <= cfg_data[CFG_WIDTH_W-1:0];
                CFG_POLYNOMIAL: poly_reg  <= cfg_data[POLY_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        cfg.poly = poly_reg;
        if (width_reg < CFG_WIDTH_W'(MIN_WIDTH))
        begin
            cfg.width = CFG_WIDTH_W'(MIN_WIDTH);
        end
        else if (width_reg > CFG_WIDTH_W'(MAX_WIDTH))
        begin
            cfg.width = CFG_WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            cfg.width = width_reg;
        end
    end

endmodule

>>> rtl/crcvw_step.sv
// ----------------------------------------------------------------------------
// CRC byte step
// Advances the remainder by one byte. The remainder, seed and polynomial
// are left-aligned in a MAX_WIDTH frame so that the eight division steps
// always test the frame's top bit, then the result is shifted back down.
// ----------------------------------------------------------------------------
module crcvw_step
    import crcvw_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)
(
    input  crc_cfg_t              cfg,
    input  logic [MAX_WIDTH-1:0]  remainder_in,
    input  logic [MAX_WIDTH-1:0]  seed,
    input  logic                  load_seed,
    input  logic [BYTE_W-1:0]     data,
    output logic [MAX_WIDTH-1:0]  remainder_out
);

    logic [CFG_WIDTH_W-1:0] shift;
    logic [MAX_WIDTH-1:0]   start;
    logic [MAX_WIDTH-1:0]   poly_al;
    logic [MAX_WIDTH-1:0]   acc;

    always_comb
    begin
        shift   = CFG_WIDTH_W'(MAX_WIDTH) - cfg.width;
        start   = load_seed ? seed : remainder_in;
        poly_al = cfg.poly[MAX_WIDTH-1:0] << shift;
        acc     = (start << shift) ^ {data, {(MAX_WIDTH-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (acc[MAX_WIDTH-1])
            begin
                acc = (acc << 1) ^ poly_al;
            end
            else
            begin
                acc = acc << 1;
            end
        end
        remainder_out = acc >> shift;
    end

endmodule

>>> rtl/crc_variable_width_byte_stream.sv
// ----------------------------------------------------------------------------
// CRC over a byte stream, MSB first, width 8 to 16 bits
// Usage: bytes enter on the in channel (valid/ready) with first_byte and
// last_byte flags. A transaction with first_byte set starts from
// seed_value; otherwise the running remainder carries on. A transaction
// with last_byte set produces one transaction on the out channel carrying
// crc_value, masked to the configured width; other bytes produce none.
// Configuration is written through cfg_we/cfg_index/cfg_data while the
// block is idle: index 0 is the width, index 1 the polynomial.
// Pipeline: a byte is held in the input register while the byte step logic
// runs; the last byte's result is then registered in the out register,
// which raises out_valid. Throughput: one byte per cycle while no stall
// holds the input register, set by the single eight-step xor network
// between the input and result registers.
// Reset: width 16, polynomial 0x1021, remainder zero, both channels empty.
// Stall: when the out register holds an untaken result, a last byte waits
// in the input register and in_ready drops; other bytes keep flowing.
// ----------------------------------------------------------------------------
module crc_variable_width_byte_stream
    import crcvw_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  first_byte,
    input  logic                  last_byte,
    input  logic [CRC_W-1:0]      seed_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CRC_W-1:0]      crc_value
);

    crc_cfg_t cfg;

    logic                  s1_valid_reg;
    logic [BYTE_W-1:0]     s1_data_reg;
    logic                  s1_first_reg;
    logic                  s1_last_reg;
    logic [MAX_WIDTH-1:0]  s1_seed_reg;
    logic                  s1_adv;

    logic [MAX_WIDTH-1:0]  rem_reg;
    logic [MAX_WIDTH-1:0]  rem_next;

    logic                  out_valid_reg;
    logic [MAX_WIDTH-1:0]  out_crc_reg;

    crcvw_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crcvw_step #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_step (
        .cfg           (cfg),
        .remainder_in  (rem_reg),
        .seed          (s1_seed_reg),
        .load_seed     (s1_first_reg),
        .data          (s1_data_reg),
        .remainder_out (rem_next)
    );

    assign s1_adv   = !s1_last_reg || !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_data_reg  <= data_byte;
            s1_first_reg <= first_byte;
            s1_last_reg  <= last_byte;
            s1_seed_reg  <= seed_value[MAX_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (s1_valid_reg && s1_adv)
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_last_reg && s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_last_reg && s1_adv)
        begin
            out_crc_reg <= rem_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign crc_value = CRC_W'(out_crc_reg);

    a_crc_masked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((crc_value >> cfg.width) == '0))
        else $error("Result has bits set at or above the configured width.");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg && s1_adv |=> out_valid_reg)
        else $error("A last byte advanced without producing a result.");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("A result appeared without a last byte.");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_data_reg)
        && $stable(rem_reg))
        else $error("Input register or remainder changed while stalled.");

endmodule
